### rtl/core/ksri_pkg.sv
// ----------------------------------------------------------------------------
// ksri_pkg: shared types and constants of the keyed sorted record insert
// Request and status codes, controller states and the field layout of the
// input and result stream words.
// ----------------------------------------------------------------------------
package ksri_pkg;

  // Field widths of the stream words.
  localparam int REQ_W      = 2;
  localparam int KEY_IN_W   = 10;
  localparam int LAYOUT_W   = 24;
  localparam int IDX_W      = 10;
  localparam int STATUS_W   = 3;
  localparam int POS_W      = 10;
  localparam int KEY_OUT_W  = 5;
  localparam int COUNT_W    = 11;

  // Input tdata layout, lowest field first.
  localparam int IN_TDATA_W = 80;
  localparam int IN_KH_LSB  = 0;
  localparam int IN_KW_LSB  = 10;
  localparam int IN_FA_LSB  = 20;
  localparam int IN_SA_LSB  = 44;
  localparam int IN_RI_LSB  = 68;

  // Result tdata layout, lowest field first.
  localparam int OUT_TDATA_W = 80;
  localparam int OUT_POS_LSB = 0;
  localparam int OUT_H_LSB   = 10;
  localparam int OUT_W_LSB   = 15;
  localparam int OUT_FA_LSB  = 20;
  localparam int OUT_SA_LSB  = 44;
  localparam int OUT_CNT_LSB = 68;
  // Position and record fields together occupy the bits below the count.
  localparam int OUT_REC_W   = 68;

  // Request codes; the unused code acts as a clear.
  typedef enum logic [REQ_W-1:0] {
    REQ_INSERT = 2'd0,
    REQ_READ   = 2'd1,
    REQ_CLEAR  = 2'd2
  } req_t;

  // Result status codes.
  typedef enum logic [STATUS_W-1:0] {
    ST_INSERTED   = 3'd0,
    ST_ZERO       = 3'd1,
    ST_FULL       = 3'd2,
    ST_RANGE      = 3'd3,
    ST_READ_OK    = 3'd4,
    ST_READ_RANGE = 3'd5,
    ST_CLEARED    = 3'd6
  } status_t;

  // Controller states.
  typedef enum logic [3:0] {
    S_SWEEP,
    S_IDLE,
    S_RD_START,
    S_RD_OFF,
    S_POS,
    S_BUMP_START,
    S_BUMP_ROW,
    S_SHIFT,
    S_PUT,
    S_READ,
    S_RESULT
  } state_t;

endpackage

### rtl/core/keyed_sorted_record_insert.sv
// ----------------------------------------------------------------------------
// keyed_sorted_record_insert: sorted record store with bucketed insertion
// Keeps records in ascending (height, width) order, equal keys in arrival
// order, using per-row start counts and per-key offsets kept in a memory.
// ----------------------------------------------------------------------------
// Insert time is set by the read-modify-write walk over the counter memory
// and the one-record-per-cycle shift through the record memory port pair.
// A clear sweeps the counter memory as reset does.
// One request is in work at a time; a finished result waits in the output
// register while the next transaction is taken.
// Reset: a sweep over the KEY_SPAN*KEY_SPAN entries zeroes the counter memory,
// with in_tready low; the record memory is not cleared.
module keyed_sorted_record_insert #(
  parameter int KEY_SPAN = 32,
  parameter int CAPACITY = 1024
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  // key_height, key_width, first_layout, second_layout, read_index, zero pad
  input  logic [ksri_pkg::IN_TDATA_W-1:0]  in_tdata,
  // req_type
  input  logic [ksri_pkg::REQ_W-1:0]       in_tuser,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  // position, out_height, out_width, out_first_layout, out_second_layout,
  // stored_count, zero pad
  output logic [ksri_pkg::OUT_TDATA_W-1:0] out_tdata,
  // status
  output logic [ksri_pkg::STATUS_W-1:0]    out_tuser
);

  import ksri_pkg::*;

  localparam int KEY_W     = $clog2(KEY_SPAN);
  localparam int J_W       = $clog2(KEY_SPAN + 1);
  localparam int CTR_DEPTH = KEY_SPAN * KEY_SPAN;
  localparam int CA_W      = $clog2(CTR_DEPTH);
  localparam int ADDR_W    = $clog2(CAPACITY);
  localparam int CNT_W     = $clog2(CAPACITY + 1);
  localparam int WIDE_W    = (CNT_W > IDX_W) ? CNT_W : IDX_W;
  localparam int REC_W     = 2 * KEY_W + 2 * LAYOUT_W;

  // Input fields.
  logic [KEY_IN_W-1:0] in_h;
  logic [KEY_IN_W-1:0] in_w;
  logic [LAYOUT_W-1:0] in_a;
  logic [LAYOUT_W-1:0] in_b;
  logic [IDX_W-1:0]    in_idx;
  logic                in_fire;

  assign in_h    = in_tdata[IN_KH_LSB +: KEY_IN_W];
  assign in_w    = in_tdata[IN_KW_LSB +: KEY_IN_W];
  assign in_a    = in_tdata[IN_FA_LSB +: LAYOUT_W];
  assign in_b    = in_tdata[IN_SA_LSB +: LAYOUT_W];
  assign in_idx  = in_tdata[IN_RI_LSB +: IDX_W];
  assign in_fire = in_tvalid && in_tready;

  // Registers.
  state_t              state_r, state_nxt;
  status_t             status_r, status_nxt;
  logic [KEY_W-1:0]    req_h_r, req_h_nxt;
  logic [KEY_W-1:0]    req_w_r, req_w_nxt;
  logic [LAYOUT_W-1:0] req_a_r, req_a_nxt;
  logic [LAYOUT_W-1:0] req_b_r, req_b_nxt;
  logic [IDX_W-1:0]    req_idx_r, req_idx_nxt;
  logic [CNT_W-1:0]    count_r, count_nxt;
  logic [CA_W-1:0]     sweep_r, sweep_nxt;
  logic [CA_W-1:0]     row_base_r, row_base_nxt;
  logic [CNT_W-1:0]    base_r, base_nxt;
  logic [ADDR_W-1:0]   pos_r, pos_nxt;
  logic [CNT_W-1:0]    left_r, left_nxt;
  logic [ADDR_W-1:0]   src_r, src_nxt;
  logic [J_W-1:0]      j_r, j_nxt;
  logic                wb_vld_r, wb_vld_nxt;
  logic [CA_W-1:0]     wb_addr_r, wb_addr_nxt;
  logic                rwb_vld_r, rwb_vld_nxt;
  logic [ADDR_W-1:0]   rwb_addr_r, rwb_addr_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic [OUT_TDATA_W-1:0] out_data_r, out_data_nxt;
  status_t             out_status_r, out_status_nxt;

  // Memory ports.
  logic              ctr_we, ctr_re;
  logic [CA_W-1:0]   ctr_waddr, ctr_raddr;
  logic [CNT_W-1:0]  ctr_wdata, ctr_rdata;
  logic              rec_we, rec_re;
  logic [ADDR_W-1:0] rec_waddr, rec_raddr;
  logic [REC_W-1:0]  rec_wdata, rec_rdata;

  // Decode of an accepted transaction.
  status_t acc_status;
  state_t  acc_state;
  logic    acc_clear;

  always_comb begin
    acc_status = ST_CLEARED;
    acc_state  = S_SWEEP;
    acc_clear  = 1'b1;
    unique case (req_t'(in_tuser))
      REQ_INSERT: begin
        acc_clear = 1'b0;
        acc_state = S_RESULT;
        if (in_h == '0) begin
          acc_status = ST_ZERO;
        end else if ((11'(in_h) >= 11'(KEY_SPAN)) || (11'(in_w) >= 11'(KEY_SPAN))) begin
          acc_status = ST_RANGE;
        end else if (count_r >= CNT_W'(CAPACITY)) begin
          acc_status = ST_FULL;
        end else begin
          acc_status = ST_INSERTED;
          acc_state  = S_RD_START;
        end
      end
      REQ_READ: begin
        acc_clear = 1'b0;
        if (WIDE_W'(in_idx) < WIDE_W'(count_r)) begin
          acc_status = ST_READ_OK;
          acc_state  = S_READ;
        end else begin
          acc_status = ST_READ_RANGE;
          acc_state  = S_RESULT;
        end
      end
      default: begin
        acc_status = ST_CLEARED;
        acc_state  = S_SWEEP;
        acc_clear  = 1'b1;
      end
    endcase
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_SWEEP: begin
        if (sweep_r == CA_W'(CTR_DEPTH - 1)) begin
          state_nxt = (status_r == ST_CLEARED) ? S_RESULT : S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_fire) begin
          state_nxt = acc_state;
        end
      end
      S_RD_START:   state_nxt = S_RD_OFF;
      S_RD_OFF:     state_nxt = S_POS;
      S_POS:        state_nxt = S_BUMP_START;
      S_BUMP_START: begin
        if (j_r >= J_W'(KEY_SPAN)) begin
          state_nxt = S_BUMP_ROW;
        end
      end
      S_BUMP_ROW: begin
        if (j_r >= J_W'(KEY_SPAN)) begin
          state_nxt = S_SHIFT;
        end
      end
      S_SHIFT: begin
        if (left_r == '0) begin
          state_nxt = S_PUT;
        end
      end
      S_PUT:  state_nxt = S_RESULT;
      S_READ: state_nxt = S_RESULT;
      S_RESULT: begin
        if (!out_valid_r || out_tready) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Datapath and memory controls.
  logic [CNT_W:0]   pos_sum;
  logic [CNT_W-1:0] pos_clamp;
  logic [CA_W-1:0]  walk_addr;

  always_comb begin
    status_nxt     = status_r;
    req_h_nxt      = req_h_r;
    req_w_nxt      = req_w_r;
    req_a_nxt      = req_a_r;
    req_b_nxt      = req_b_r;
    req_idx_nxt    = req_idx_r;
    count_nxt      = count_r;
    sweep_nxt      = sweep_r;
    row_base_nxt   = row_base_r;
    base_nxt       = base_r;
    pos_nxt        = pos_r;
    left_nxt       = left_r;
    src_nxt        = src_r;
    j_nxt          = j_r;
    wb_vld_nxt     = 1'b0;
    wb_addr_nxt    = wb_addr_r;
    rwb_vld_nxt    = 1'b0;
    rwb_addr_nxt   = rwb_addr_r;
    out_valid_nxt  = out_valid_r && !out_tready;
    out_data_nxt   = out_data_r;
    out_status_nxt = out_status_r;

    ctr_re    = 1'b0;
    ctr_raddr = '0;
    ctr_we    = wb_vld_r;
    ctr_waddr = wb_addr_r;
    ctr_wdata = ctr_rdata + CNT_W'(1);
    rec_re    = 1'b0;
    rec_raddr = '0;
    rec_we    = rwb_vld_r;
    rec_waddr = rwb_addr_r;
    rec_wdata = rec_rdata;

    pos_sum   = {1'b0, base_r} + {1'b0, ctr_rdata};
    pos_clamp = (pos_sum > {1'b0, count_r}) ? count_r : pos_sum[CNT_W-1:0];
    walk_addr = (state_r == S_BUMP_START) ? CA_W'(j_r) : (row_base_r + CA_W'(j_r));

    unique case (state_r)
      // Zero one counter entry per cycle.
      S_SWEEP: begin
        ctr_we    = 1'b1;
        ctr_waddr = sweep_r;
        ctr_wdata = '0;
        sweep_nxt = (sweep_r == CA_W'(CTR_DEPTH - 1)) ? '0 : sweep_r + CA_W'(1);
      end
      // Take a transaction and register its fields.
      S_IDLE: begin
        if (in_fire) begin
          status_nxt  = acc_status;
          req_h_nxt   = in_h[KEY_W-1:0];
          req_w_nxt   = in_w[KEY_W-1:0];
          req_a_nxt   = in_a;
          req_b_nxt   = in_b;
          req_idx_nxt = in_idx;
          if (acc_clear) begin
            count_nxt = '0;
            sweep_nxt = '0;
          end
        end
      end
      // Row start of the key height; row 0 of the counter memory holds it.
      S_RD_START: begin
        ctr_re       = 1'b1;
        ctr_raddr    = CA_W'(req_h_r);
        row_base_nxt = CA_W'(req_h_r * KEY_SPAN);
      end
      // Offset of the key pair within its row.
      S_RD_OFF: begin
        ctr_re    = 1'b1;
        ctr_raddr = row_base_r + CA_W'(req_w_r);
        base_nxt  = ctr_rdata;
      end
      // Insert position and shift span.
      S_POS: begin
        pos_nxt  = ADDR_W'(pos_clamp);
        left_nxt = count_r - pos_clamp;
        src_nxt  = ADDR_W'(count_r - CNT_W'(1));
        j_nxt    = J_W'(req_h_r) + J_W'(1);
      end
      // Bump row starts above the key height, then offsets from the key width.
      S_BUMP_START, S_BUMP_ROW: begin
        if (j_r < J_W'(KEY_SPAN)) begin
          ctr_re      = 1'b1;
          ctr_raddr   = walk_addr;
          wb_vld_nxt  = 1'b1;
          wb_addr_nxt = walk_addr;
          j_nxt       = j_r + J_W'(1);
        end else if (state_r == S_BUMP_START) begin
          j_nxt = J_W'(req_w_r);
        end
      end
      // Move records up one place, highest first.
      S_SHIFT: begin
        if (left_r != '0) begin
          rec_re       = 1'b1;
          rec_raddr    = src_r;
          rwb_vld_nxt  = 1'b1;
          rwb_addr_nxt = src_r + ADDR_W'(1);
          src_nxt      = src_r - ADDR_W'(1);
          left_nxt     = left_r - CNT_W'(1);
        end
      end
      // Write the new record into the opened slot.
      S_PUT: begin
        rec_we    = 1'b1;
        rec_waddr = pos_r;
        rec_wdata = {req_b_r, req_a_r, req_w_r, req_h_r};
        count_nxt = count_r + CNT_W'(1);
      end
      S_READ: begin
        rec_re    = 1'b1;
        rec_raddr = ADDR_W'(WIDE_W'(req_idx_r));
      end
      // Load the result into the output register once it is free.
      S_RESULT: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = status_r;
          out_data_nxt   = '0;
          out_data_nxt[OUT_CNT_LSB +: COUNT_W] = COUNT_W'(count_r);
          if (status_r == ST_INSERTED) begin
            out_data_nxt[OUT_POS_LSB +: POS_W]     = POS_W'(pos_r);
            out_data_nxt[OUT_H_LSB +: KEY_OUT_W]   = KEY_OUT_W'(req_h_r);
            out_data_nxt[OUT_W_LSB +: KEY_OUT_W]   = KEY_OUT_W'(req_w_r);
            out_data_nxt[OUT_FA_LSB +: LAYOUT_W]   = req_a_r;
            out_data_nxt[OUT_SA_LSB +: LAYOUT_W]   = req_b_r;
          end else if (status_r == ST_READ_OK) begin
            out_data_nxt[OUT_POS_LSB +: POS_W]     = req_idx_r;
            out_data_nxt[OUT_H_LSB +: KEY_OUT_W]   = KEY_OUT_W'(rec_rdata[0 +: KEY_W]);
            out_data_nxt[OUT_W_LSB +: KEY_OUT_W]   = KEY_OUT_W'(rec_rdata[KEY_W +: KEY_W]);
            out_data_nxt[OUT_FA_LSB +: LAYOUT_W]   = rec_rdata[2*KEY_W +: LAYOUT_W];
            out_data_nxt[OUT_SA_LSB +: LAYOUT_W]   = rec_rdata[2*KEY_W+LAYOUT_W +: LAYOUT_W];
          end else if (status_r == ST_READ_RANGE) begin
            out_data_nxt[OUT_POS_LSB +: POS_W]     = req_idx_r;
          end
        end
      end
      default: begin
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_SWEEP;
      status_r    <= ST_INSERTED;
      count_r     <= '0;
      sweep_r     <= '0;
      wb_vld_r    <= 1'b0;
      rwb_vld_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      status_r    <= status_nxt;
      count_r     <= count_nxt;
      sweep_r     <= sweep_nxt;
      wb_vld_r    <= wb_vld_nxt;
      rwb_vld_r   <= rwb_vld_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    req_h_r      <= req_h_nxt;
    req_w_r      <= req_w_nxt;
    req_a_r      <= req_a_nxt;
    req_b_r      <= req_b_nxt;
    req_idx_r    <= req_idx_nxt;
    row_base_r   <= row_base_nxt;
    base_r       <= base_nxt;
    pos_r        <= pos_nxt;
    left_r       <= left_nxt;
    src_r        <= src_nxt;
    j_r          <= j_nxt;
    wb_addr_r    <= wb_addr_nxt;
    rwb_addr_r   <= rwb_addr_nxt;
    out_data_r   <= out_data_nxt;
    out_status_r <= out_status_nxt;
  end

  // Row start and per-key offset counters.
  ksri_ram #(
    .WIDTH (CNT_W),
    .DEPTH (CTR_DEPTH)
  ) u_ctr_ram (
    .clk   (clk),
    .we    (ctr_we),
    .waddr (ctr_waddr),
    .wdata (ctr_wdata),
    .re    (ctr_re),
    .raddr (ctr_raddr),
    .rdata (ctr_rdata)
  );

  // Sorted record store.
  ksri_ram #(
    .WIDTH (REC_W),
    .DEPTH (CAPACITY)
  ) u_rec_ram (
    .clk   (clk),
    .we    (rec_we),
    .waddr (rec_waddr),
    .wdata (rec_wdata),
    .re    (rec_re),
    .raddr (rec_raddr),
    .rdata (rec_rdata)
  );

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_status_r;

endmodule

### rtl/core/ksri_ram.sv
// ----------------------------------------------------------------------------
// ksri_ram: generic simple dual-port RAM
// One write port and one read port; read data is registered and holds its
// value while no read is enabled.
// ----------------------------------------------------------------------------
module ksri_ram #(
  parameter  int WIDTH = 8,
  parameter  int DEPTH = 16,
  localparam int AW    = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

### rtl/core/ksri_checker.sv
// ----------------------------------------------------------------------------
// ksri_checker: port-level assertions for the keyed sorted record insert
// Watches the stream ports only and is bound to the top level.
// ----------------------------------------------------------------------------
module ksri_checker (
  input logic                             clk,
  input logic                             rst_n,
  input logic                             in_tvalid,
  input logic                             in_tready,
  input logic                             out_tvalid,
  input logic                             out_tready,
  input logic [ksri_pkg::OUT_TDATA_W-1:0] out_tdata,
  input logic [ksri_pkg::STATUS_W-1:0]    out_tuser
);

  import ksri_pkg::*;

  logic [1:0] pend_r, pend_nxt;
  logic       in_fire, out_fire;

  assign in_fire  = in_tvalid && in_tready;
  assign out_fire = out_tvalid && out_tready;

  // Transactions accepted but not yet answered.
  always_comb begin
    pend_nxt = pend_r + 2'(in_fire) - 2'(out_fire);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= '0;
    end else begin
      pend_r <= pend_nxt;
    end
  end

  // A stalled result holds.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result changed while stalled");

  // Every result answers an accepted transaction.
  a_no_extra: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> pend_r != 2'd0)
    else $error("result without a pending transaction");

  // Dropped inserts and clears carry no position and no record.
  a_drop_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser == ST_ZERO || out_tuser == ST_RANGE ||
                   out_tuser == ST_FULL || out_tuser == ST_CLEARED)
    |-> out_tdata[OUT_REC_W-1:0] == '0)
    else $error("dropped result carries record data");

  // A clear leaves the store empty.
  a_clear_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser == ST_CLEARED |-> out_tdata[OUT_CNT_LSB +: COUNT_W] == '0)
    else $error("clear result reports stored records");

endmodule

bind keyed_sorted_record_insert ksri_checker u_ksri_checker (.*);
